// ===== src/trs_pkg.sv =====
// Constants for the scale, rotate and translate matrix builder.
package trs_pkg;

  localparam int CORDIC_STEPS = 17;
  localparam int ZW = 21;

  localparam logic signed [ZW-1:0] PI_Q16 = 21'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
    21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32, 21'sd16,
    21'sd8, 21'sd4, 21'sd2, 21'sd1
  };

  typedef logic signed [33:0] q30_t;

endpackage

// ===== src/trs_matrix_builder.sv =====
// Scale, rotate and translate 4x4 matrix builder, top level.
// Usage:
//   Input: an item is taken at a rising edge with start high and busy low.
//   busy goes high after each accepted item and holds off the next item,
//   so that the four-row output serializer sharing one result port keeps up.
//   Output: four rows per item, rows 0..3 on consecutive cycles, each shown
//   for one cycle with out_valid high; out_last_row marks row 3.
//   Work: angle reduction, 17 CORDIC stages for the three angles in
//   parallel, two product stages for the rotation matrix, one add stage,
//   then scale and translation product, rounding and saturation stages.
//   Reset: rst_n clears busy and all valid bits; items in flight are
//   dropped.
//   The receiver cannot stall; rows are delivered as soon as they are ready.
module trs_matrix_builder
  import trs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  input  logic signed [31:0] in_shift_x,
  input  logic signed [31:0] in_shift_y,
  input  logic signed [31:0] in_shift_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  output logic               out_valid,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_last_row
);

  function automatic logic [ZW:0] reduce(input logic signed [15:0] a);
    logic signed [ZW-1:0] z;
    logic f;
    z = {{(ZW-20){a[15]}}, a, 4'b0000};
    f = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (z > HALF_PI_Q16) begin
        z = z - PI_Q16;
        f = ~f;
      end else if (z < -HALF_PI_Q16) begin
        z = z + PI_Q16;
        f = ~f;
      end
    end
    return {f, z};
  endfunction

  function automatic q30_t m30(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    logic signed [67:0] r;
    p = 68'(a) * 68'(b);
    r = (p + 68'sd536870912) >>> 30;
    return r[33:0];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [55:0] v);
    if (v > 56'sd2147483647) return 32'sh7fffffff;
    if (v < -56'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [1:0] bcnt_r;
  logic       accept;
  assign busy = (bcnt_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 2'd0;
    end else if (accept) begin
      bcnt_r <= 2'd3;
    end else if (bcnt_r != 2'd0) begin
      bcnt_r <= bcnt_r - 2'd1;
    end
  end

  // CORDIC pipeline
  logic                 cv_r [0:CORDIC_STEPS];
  logic signed [31:0]   x_r  [0:CORDIC_STEPS][3];
  logic signed [31:0]   y_r  [0:CORDIC_STEPS][3];
  logic signed [ZW-1:0] z_r  [0:CORDIC_STEPS][3];
  logic                 f_r  [0:CORDIC_STEPS][3];
  logic signed [31:0]   sc_r [0:CORDIC_STEPS][3];
  logic signed [31:0]   t_r  [0:CORDIC_STEPS][3];
  logic [ZW:0]          red  [3];

  always_comb begin
    red[0] = reduce(in_angle_x);
    red[1] = reduce(in_angle_y);
    red[2] = reduce(in_angle_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) cv_r[k] <= 1'b0;
    end else begin
      cv_r[0] <= accept;
      for (int k = 0; k < CORDIC_STEPS; k++) cv_r[k+1] <= cv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      x_r[0][a] <= GAIN_Q30;
      y_r[0][a] <= 32'sd0;
      z_r[0][a] <= red[a][ZW-1:0];
      f_r[0][a] <= red[a][ZW];
    end
    sc_r[0][0] <= in_scale_x;
    sc_r[0][1] <= in_scale_y;
    sc_r[0][2] <= in_scale_z;
    t_r[0][0] <= in_shift_x;
    t_r[0][1] <= in_shift_y;
    t_r[0][2] <= in_shift_z;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      for (int a = 0; a < 3; a++) begin
        if (z_r[k][a] >= 0) begin
          x_r[k+1][a] <= x_r[k][a] - (y_r[k][a] >>> k);
          y_r[k+1][a] <= y_r[k][a] + (x_r[k][a] >>> k);
          z_r[k+1][a] <= z_r[k][a] - ATAN_Q16[k];
        end else begin
          x_r[k+1][a] <= x_r[k][a] + (y_r[k][a] >>> k);
          y_r[k+1][a] <= y_r[k][a] - (x_r[k][a] >>> k);
          z_r[k+1][a] <= z_r[k][a] + ATAN_Q16[k];
        end
        f_r[k+1][a] <= f_r[k][a];
        sc_r[k+1][a] <= sc_r[k][a];
        t_r[k+1][a] <= t_r[k][a];
      end
    end
  end

  // sine and cosine with reduction sign applied
  q30_t sn [3];
  q30_t cs [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sn[a] = f_r[CORDIC_STEPS][a] ? -34'(y_r[CORDIC_STEPS][a])
                                   : 34'(y_r[CORDIC_STEPS][a]);
      cs[a] = f_r[CORDIC_STEPS][a] ? -34'(x_r[CORDIC_STEPS][a])
                                   : 34'(x_r[CORDIC_STEPS][a]);
    end
  end

  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0;
      ve_r <= 1'b0; vf_r <= 1'b0; vg_r <= 1'b0;
    end else begin
      va_r <= cv_r[CORDIC_STEPS];
      vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r;
      ve_r <= vd_r; vf_r <= ve_r; vg_r <= vf_r;
    end
  end

  // stage A: first products
  q30_t sysx_r, cysx_r, cycz_r, cysz_r, sycx_r, cxsz_r, cxcz_r, sysz_r, sycz_r, cycx_r;
  q30_t sza_r, cza_r, sxa_r;
  logic signed [31:0] sca_r [3];
  logic signed [31:0] ta_r  [3];
  always_ff @(posedge clk) begin
    sysx_r <= m30(sn[1], sn[0]);
    cysx_r <= m30(cs[1], sn[0]);
    cycz_r <= m30(cs[1], cs[2]);
    cysz_r <= m30(cs[1], sn[2]);
    sycx_r <= m30(sn[1], cs[0]);
    cxsz_r <= m30(cs[0], sn[2]);
    cxcz_r <= m30(cs[0], cs[2]);
    sysz_r <= m30(sn[1], sn[2]);
    sycz_r <= m30(sn[1], cs[2]);
    cycx_r <= m30(cs[1], cs[0]);
    sza_r <= sn[2];
    cza_r <= cs[2];
    sxa_r <= sn[0];
    for (int a = 0; a < 3; a++) begin
      sca_r[a] <= sc_r[CORDIC_STEPS][a];
      ta_r[a] <= t_r[CORDIC_STEPS][a];
    end
  end

  // stage B: triple products
  q30_t sysxsz_r, sysxcz_r, cysxsz_r, cysxcz_r;
  q30_t cyczb_r, cyszb_r, sycxb_r, cxszb_r, cxczb_r, syszb_r, syczb_r, cycxb_r, sxb_r;
  logic signed [31:0] scb_r [3];
  logic signed [31:0] tb_r  [3];
  always_ff @(posedge clk) begin
    sysxsz_r <= m30(sysx_r, sza_r);
    sysxcz_r <= m30(sysx_r, cza_r);
    cysxsz_r <= m30(cysx_r, sza_r);
    cysxcz_r <= m30(cysx_r, cza_r);
    cyczb_r <= cycz_r; cyszb_r <= cysz_r; sycxb_r <= sycx_r;
    cxszb_r <= cxsz_r; cxczb_r <= cxcz_r; syszb_r <= sysz_r;
    syczb_r <= sycz_r; cycxb_r <= cycx_r; sxb_r <= sxa_r;
    scb_r <= sca_r;
    tb_r <= ta_r;
  end

  // stage C: rotation matrix
  q30_t rc_r [3][3];
  logic signed [31:0] scc_r [3];
  logic signed [31:0] tc_r  [3];
  always_ff @(posedge clk) begin
    rc_r[0][0] <= cyczb_r + sysxsz_r;
    rc_r[0][1] <= sysxcz_r - cyszb_r;
    rc_r[0][2] <= sycxb_r;
    rc_r[1][0] <= cxszb_r;
    rc_r[1][1] <= cxczb_r;
    rc_r[1][2] <= -sxb_r;
    rc_r[2][0] <= cysxsz_r - syczb_r;
    rc_r[2][1] <= syszb_r + cysxcz_r;
    rc_r[2][2] <= cycxb_r;
    scc_r <= scb_r;
    tc_r <= tb_r;
  end

  // stage D: scale and translation products
  logic signed [65:0] p_r [3][3];
  logic signed [65:0] q_r [3][3];
  logic signed [31:0] scd_r [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_r[i][j] <= 66'(scc_r[i]) * 66'(rc_r[i][j]);
        q_r[i][j] <= 66'(rc_r[i][j]) * 66'(tc_r[j]);
      end
    end
    scd_r <= scc_r;
  end

  // stage E: round and saturate columns 0..2, sum translation
  logic signed [31:0] cole_r [3][3];
  logic signed [37:0] d16_r [3];
  logic signed [31:0] sce_r [3];
  logic signed [67:0] dsum [3];
  logic signed [67:0] drnd [3];
  logic signed [65:0] prnd [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i] = 68'(q_r[i][0]) + 68'(q_r[i][1]) + 68'(q_r[i][2]);
      drnd[i] = (dsum[i] + 68'sd536870912) >>> 30;
      for (int j = 0; j < 3; j++) begin
        prnd[i][j] = (p_r[i][j] + 66'sd536870912) >>> 30;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d16_r[i] <= drnd[i][37:0];
      for (int j = 0; j < 3; j++) begin
        cole_r[i][j] <= sat(56'($signed(prnd[i][j][35:0])));
      end
    end
    sce_r <= scd_r;
  end

  // stage F: split products for column 3
  logic signed [53:0] hp_r [3];
  logic signed [48:0] lp_r [3];
  logic signed [31:0] colf_r [3][3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hp_r[i] <= 54'(sce_r[i]) * 54'($signed(d16_r[i][37:16]));
      lp_r[i] <= 49'(sce_r[i]) * 49'($signed({1'b0, d16_r[i][15:0]}));
    end
    colf_r <= cole_r;
  end

  // stage G: column 3 round and saturate
  logic signed [31:0] colg_r [3][4];
  logic signed [48:0] lrnd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lrnd[i] = (lp_r[i] + 49'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) colg_r[i][j] <= colf_r[i][j];
      colg_r[i][3] <= sat(56'(hp_r[i]) + 56'(lrnd[i]));
    end
  end

  // output serializer
  logic signed [31:0] hold_r [1:2][4];
  logic [1:0]         row_r;
  logic               emit_r;
  logic signed [31:0] oc_r [4];
  logic               ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      emit_r <= 1'b0;
      row_r <= 2'd0;
    end else if (vg_r) begin
      ov_r <= 1'b1;
      emit_r <= 1'b1;
      row_r <= 2'd0;
    end else if (emit_r) begin
      ov_r <= 1'b1;
      row_r <= row_r + 2'd1;
      emit_r <= (row_r != 2'd2);
    end else begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vg_r) begin
      oc_r <= colg_r[0];
      hold_r[1] <= colg_r[1];
      hold_r[2] <= colg_r[2];
    end else if (row_r == 2'd0) begin
      oc_r <= hold_r[1];
    end else if (row_r == 2'd1) begin
      oc_r <= hold_r[2];
    end else begin
      oc_r[0] <= 32'sd0;
      oc_r[1] <= 32'sd0;
      oc_r[2] <= 32'sd0;
      oc_r[3] <= ONE_Q16;
    end
  end

  assign out_valid = ov_r;
  assign out_row_index = row_r;
  assign out_col0 = oc_r[0];
  assign out_col1 = oc_r[1];
  assign out_col2 = oc_r[2];
  assign out_col3 = oc_r[3];
  assign out_last_row = (row_r == 2'd3);

endmodule

// ===== tb/trs_matrix_builder_tb.sv =====
// Self-checking testbench for the scale, rotate and translate matrix builder.
`timescale 1ns / 1ps

module trs_matrix_builder_tb;
  import trs_pkg::*;

  typedef struct {
    logic signed [31:0] scale [3];
    logic signed [31:0] shift [3];
    logic signed [15:0] angle [3];
  } trs_item_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] col [4];
    logic               last;
  } matrix_row_t;

  typedef struct {
    trs_item_t   item;
    logic        typed;
    matrix_row_t row0;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic signed [15:0] A_MAX = 16'sh7fff;
  localparam logic signed [15:0] A_MIN = 16'sh8000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_scale_x, in_scale_y, in_scale_z;
  logic signed [31:0] in_shift_x, in_shift_y, in_shift_z;
  logic signed [15:0] in_angle_x, in_angle_y, in_angle_z;
  logic               out_valid;
  logic [1:0]         out_row_index;
  logic signed [31:0] out_col0, out_col1, out_col2, out_col3;
  logic               out_last_row;

  matrix_row_t expected_rows [$];
  int          errors;
  int          items_sent;
  int          rows_seen;
  int          idle_cycles;

  trs_matrix_builder DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_q30(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return S_MAX;
    if (v < -64'sd2147483648) return S_MIN;
    return v[31:0];
  endfunction

  task automatic cordic_sincos(input logic signed [15:0] ang, output longint s,
                               output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 16;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    for (int k = 0; k < 4; k++) begin
      if (z > HALF_PI_Q16) begin
        z -= PI_Q16;
        flip = !flip;
      end else if (z < -longint'(HALF_PI_Q16)) begin
        z += PI_Q16;
        flip = !flip;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q16[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q16[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic build_matrix_rows(input trs_item_t it);
    longint sx, cx, sy, cy, sz, cz, sysx, cysx;
    longint r [3][3];
    longint d, d16, hi, lo, sc;
    matrix_row_t mr;
    cordic_sincos(it.angle[0], sx, cx);
    cordic_sincos(it.angle[1], sy, cy);
    cordic_sincos(it.angle[2], sz, cz);
    sysx = round_q30(sy, sx);
    cysx = round_q30(cy, sx);
    r[0][0] = round_q30(cy, cz) + round_q30(sysx, sz);
    r[0][1] = round_q30(sysx, cz) - round_q30(cy, sz);
    r[0][2] = round_q30(sy, cx);
    r[1][0] = round_q30(cx, sz);
    r[1][1] = round_q30(cx, cz);
    r[1][2] = -sx;
    r[2][0] = round_q30(cysx, sz) - round_q30(sy, cz);
    r[2][1] = round_q30(sy, sz) + round_q30(cysx, cz);
    r[2][2] = round_q30(cy, cx);
    for (int i = 0; i < 3; i++) begin
      sc = it.scale[i];
      d = 0;
      for (int j = 0; j < 3; j++) begin
        mr.col[j] = clamp32(floor_shift(sc * r[i][j] + (64'sd1 <<< 29), 30));
        d += r[i][j] * longint'(it.shift[j]);
      end
      d16 = floor_shift(d + (64'sd1 <<< 29), 30);
      hi = floor_shift(d16, 16);
      lo = d16 - hi * 65536;
      mr.col[3] = clamp32(sc * hi + floor_shift(sc * lo + (64'sd1 <<< 15), 16));
      mr.row = i[1:0];
      mr.last = 1'b0;
      expected_rows.push_back(mr);
    end
    mr.row = 2'd3;
    mr.col = '{32'sd0, 32'sd0, 32'sd0, ONE_Q16};
    mr.last = 1'b1;
    expected_rows.push_back(mr);
  endtask

  function automatic trs_item_t make_item(logic signed [31:0] s, logic signed [31:0] t,
                                          logic signed [15:0] a);
    trs_item_t it;
    it.scale = '{s, s, s};
    it.shift = '{t, t, t};
    it.angle = '{a, a, a};
    return it;
  endfunction

  function automatic trs_item_t random_item();
    trs_item_t it;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: it.scale[i] = $urandom;
        1: it.scale[i] = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
        default: it.scale[i] = $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      endcase
      it.shift[i] = $urandom_range(0, 2) == 0 ? $urandom
                    : $signed($urandom_range(0, 32'hfffff)) - 32'sh80000;
      it.angle[i] = $urandom_range(0, 3) == 0 ? 16'($urandom)
                    : 16'($signed($urandom_range(0, 16'h3243)) - 16'sh1922);
    end
    return it;
  endfunction

  task automatic send_item(input trs_item_t it);
    in_scale_x <= it.scale[0];
    in_scale_y <= it.scale[1];
    in_scale_z <= it.scale[2];
    in_shift_x <= it.shift[0];
    in_shift_y <= it.shift[1];
    in_shift_z <= it.shift[2];
    in_angle_x <= it.angle[0];
    in_angle_y <= it.angle[1];
    in_angle_z <= it.angle[2];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    build_matrix_rows(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: n = 0;
      9: n = $urandom_range(10, 40);
      default: n = $urandom_range(1, 4);
    endcase
    if (n > 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    matrix_row_t e;
    if (rst_n) begin
      if (out_valid) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          $error("unexpected row %0d with nothing pending", out_row_index);
          errors++;
        end else begin
          e = expected_rows.pop_front();
          check_field("row_index", e.row, out_row_index);
          check_field("col0", e.col[0], out_col0);
          check_field("col1", e.col[1], out_col1);
          check_field("col2", e.col[2], out_col2);
          check_field("col3", e.col[3], out_col3);
          check_field("last_row", e.last, out_last_row);
        end
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d rows pending", expected_rows.size());
        $display("** trs_matrix_builder: FAILED **");
        $finish;
      end
    end
  end

  stim_row_t directed [$];

  task automatic add_row(trs_item_t it, logic typed, matrix_row_t r0);
    stim_row_t s;
    s.item = it;
    s.typed = typed;
    s.row0 = r0;
    directed.push_back(s);
  endtask

  initial begin
    trs_item_t it;
    matrix_row_t none;
    none.row = 2'd0;
    none.col = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
    none.last = 1'b0;
    errors = 0;
    items_sent = 0;
    rows_seen = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_scale_x, in_scale_y, in_scale_z, in_shift_x, in_shift_y, in_shift_z} = '0;
    {in_angle_x, in_angle_y, in_angle_z} = '0;

    add_row(make_item(32'sd0, 32'sd0, 16'sd0), 1'b1, none);
    add_row(make_item(ONE_Q16, 32'sd0, 16'sd0), 1'b0, none);
    add_row(make_item(S_MAX, S_MAX, 16'sd0), 1'b0, none);
    add_row(make_item(S_MIN, S_MIN, 16'sd0), 1'b0, none);
    add_row(make_item(S_MAX, S_MIN, A_MAX), 1'b0, none);
    add_row(make_item(S_MIN, S_MAX, A_MIN), 1'b0, none);
    add_row(make_item(-32'sd1, -32'sd1, -16'sd1), 1'b0, none);
    add_row(make_item(ONE_Q16, 32'sd65536, 16'sd6434), 1'b0, none);
    add_row(make_item(ONE_Q16, 32'sd65536, -16'sd6434), 1'b0, none);
    add_row(make_item(ONE_Q16, 32'sd65536, 16'sd12868), 1'b0, none);
    add_row(make_item(ONE_Q16, 32'sd65536, -16'sd12868), 1'b0, none);
    add_row(make_item(32'sd327680, 32'sd1000000, 16'sd3217), 1'b0, none);
    it = make_item(ONE_Q16, 32'sd0, 16'sd0);
    it.angle = '{A_MAX, 16'sd0, A_MIN};
    add_row(it, 1'b0, none);
    it.scale = '{S_MAX, S_MIN, 32'sd1};
    it.shift = '{S_MIN, 32'sd0, S_MAX};
    it.angle = '{16'sd4096, A_MIN, 16'sd2048};
    add_row(it, 1'b0, none);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[k]) begin
      if (directed[k].typed) begin
        send_item(directed[k].item);
        expected_rows[$-3] = directed[k].row0;
      end else begin
        send_item(directed[k].item);
      end
      idle_gap();
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(random_item());
      if (n < 40 || n > 80) idle_gap();
    end
    start <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d directed, rest random); checked %0d matrix rows.",
             items_sent, directed.size(), rows_seen);
    if (errors == 0) begin
      $display("** trs_matrix_builder: PASSED **");
    end else begin
      $display("** trs_matrix_builder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== trs_matrix_builder.f =====
src/trs_pkg.sv
src/trs_matrix_builder.sv
tb/trs_matrix_builder_tb.sv
